// File: hdl/fyxs_pkg.sv
package fyxs_pkg;

  // Replacement for a zero seed
  localparam logic [31:0] SEED_SUBST = 32'h0000_CAFE;

  // One xorshift32 step; zero maps to one
  function automatic logic [31:0] xs_step(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    c = b ^ (b << 5);
    xs_step = (c == 32'd0) ? 32'd1 : c;
  endfunction

endpackage

// File: hdl/fisher_yates_xorshift_shuffle.sv
// Load: one word per cycle, in_tready high while loading a set of n words.
// Shuffle after the last word: each swap takes a generator step, the serial
// remainder, two reads and two writes on the item RAM; n-1 swaps, none for n=1.
// Emit: each word takes a RAM read (S_ORD) and an output register load (S_OUT), and
// waits while out_tready is low; input is held off until the final word sits in the output register.
// Reset (synchronous, rst_n low) clears control state and generator; RAM is not cleared.
module fisher_yates_xorshift_shuffle #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [15:0] item_in, [47:16] seed
  input  logic        in_tlast,    // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] item_out
  output logic        out_tlast    // last_out
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_GEN   = 9'b000000010,
    S_MOD   = 9'b000000100,
    S_RDI   = 9'b000001000,
    S_RDJ   = 9'b000010000,
    S_WRI   = 9'b000100000,
    S_WRJ   = 9'b001000000,
    S_ORD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } st_t;

  st_t            st_r, st_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  i_r, i_nxt;
  logic [AW-1:0]  j_r, j_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  logic [31:0]    gen_r, gen_nxt;
  logic [15:0]    ti_r, ti_nxt;
  logic           ov_r, ov_nxt;
  logic [15:0]    od_r, od_nxt;
  logic           ol_r, ol_nxt;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;
  logic           mstart, mdone;
  logic [CW-1:0]  mrem;
  logic [CW-1:0]  bound;
  logic           acc_in, acc_out;
  logic [31:0]    seed_in;

  assign in_tready  = (st_r == S_LOAD);
  assign acc_in     = in_tvalid && in_tready;
  assign acc_out    = out_tvalid && out_tready;
  assign seed_in    = in_tdata[47:16];
  assign bound      = CW'({1'b0, i_r}) + CW'(1);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  fyxs_ram #(.WIDTH(16), .DEPTH(MAX_ITEMS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Remainder unit loads the freshly advanced generator value
  fyxs_mod #(.DW(CW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mstart), .dividend(gen_nxt),
    .divisor(bound), .done(mdone), .rem(mrem)
  );

  // Sequencer
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    gen_nxt = gen_r;
    ti_nxt  = ti_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    ol_nxt  = ol_r;
    we      = 1'b0;
    waddr   = cnt_r[AW-1:0];
    wdata   = in_tdata[15:0];
    raddr   = i_r;
    mstart  = 1'b0;
    if (acc_out) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      S_LOAD: begin
        if (acc_in) begin
          logic [CW-1:0] n;
          n = cnt_r;
          if (cnt_r == '0) begin
            gen_nxt = (seed_in == 32'd0) ? fyxs_pkg::SEED_SUBST : seed_in;
          end
          if (cnt_r < CW'(MAX_ITEMS)) begin
            we = 1'b1;
            n  = cnt_r + CW'(1);
          end
          cnt_nxt = n;
          if (in_tlast) begin
            i_nxt = AW'(n - CW'(1));
            k_nxt = '0;
            st_nxt = (n == CW'(1)) ? S_ORD : S_GEN;
          end
        end
      end
      S_GEN: begin
        gen_nxt = fyxs_pkg::xs_step(gen_r);
        mstart  = 1'b1;
        st_nxt  = S_MOD;
      end
      S_MOD: begin
        if (mdone) begin
          j_nxt  = mrem[AW-1:0];
          st_nxt = S_RDI;
        end
      end
      S_RDI: begin
        raddr  = i_r;
        st_nxt = S_RDJ;
      end
      S_RDJ: begin
        raddr  = j_r;
        ti_nxt = rdata;
        st_nxt = S_WRI;
      end
      S_WRI: begin
        we     = 1'b1;
        waddr  = i_r;
        wdata  = rdata;
        st_nxt = S_WRJ;
      end
      S_WRJ: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = ti_r;
        if (i_r == AW'(1)) begin
          st_nxt = S_ORD;
        end else begin
          i_nxt  = i_r - AW'(1);
          st_nxt = S_GEN;
        end
      end
      S_ORD: begin
        raddr = k_r;
        if (!ov_r || acc_out) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        raddr  = k_r;
        ov_nxt = 1'b1;
        od_nxt = rdata;
        ol_nxt = (CW'({1'b0, k_r}) + CW'(1) == cnt_r);
        if (ol_nxt) begin
          cnt_nxt = '0;
          st_nxt  = S_LOAD;
        end else begin
          k_nxt  = k_r + AW'(1);
          st_nxt = S_ORD;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_LOAD;
      cnt_r <= '0;
      ov_r  <= 1'b0;
      gen_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
      gen_r <= gen_nxt;
    end
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    ti_r <= ti_nxt;
    od_r <= od_nxt;
    ol_r <= ol_nxt;
  end

  // Input is only taken while loading
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_LOAD) |-> !in_tready) else $error("input taken while busy");
  // Item count never exceeds capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS)) else $error("item count overflow");
  // Swap index stays within bound
  a_j_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RDI) |-> (j_r <= i_r)) else $error("swap index out of range");
  // Output word is never overwritten while waiting
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r) else $error("output word lost");

endmodule

// File: hdl/fyxs_ram.sv
module fyxs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/fyxs_mod.sv
// Serial restoring remainder: one quotient bit per cycle across the 32-bit dividend
module fyxs_mod #(
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  logic [31:0]   sh_r, sh_nxt;
  logic [DW:0]   acc_r, acc_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  assign trial = {acc_r[DW-1:0], sh_r[31]};
  assign done  = busy_r && (cnt_r == 6'd0);
  assign rem   = acc_r[DW-1:0];

  always_comb begin
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      sh_nxt   = dividend;
      acc_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != 6'd0) begin
      // shift in one bit, subtract when it fits
      sh_nxt  = {sh_r[30:0], 1'b0};
      acc_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r - 6'd1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

endmodule
